>>> rtl/store_buffer_with_forwarding_core_macros.svh
// Assertion macros shared by the store buffer RTL.
`ifndef STORE_BUFFER_WITH_FORWARDING_CORE_MACROS_SVH
`define STORE_BUFFER_WITH_FORWARDING_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("store buffer check failed");
`define SBF_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("store buffer reset check failed");
`else
`define SBF_ASSERT(lbl, prop)
`define SBF_ASSERT_NORST(lbl, prop)
`endif

`endif

>>> rtl/sbf_pkg.sv
// Shared types and codes of the store buffer.
`default_nettype none

package sbf_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FENCE = 2'd2;
  localparam logic [1:0] OP_DRAIN = 2'd3;

  localparam logic [2:0] STS_READ_HIT  = 3'd0;
  localparam logic [2:0] STS_READ_MISS = 3'd1;
  localparam logic [2:0] STS_QUEUED    = 3'd2;
  localparam logic [2:0] STS_MERGED    = 3'd3;
  localparam logic [2:0] STS_FULL      = 3'd4;
  localparam logic [2:0] STS_FENCE     = 3'd5;
  localparam logic [2:0] STS_DRAINED   = 3'd6;
  localparam logic [2:0] STS_EMPTY     = 3'd7;

  // Contents of one buffer entry, as handed between neighbouring cells.
  typedef struct packed {
    logic        valid;
    logic        fence;
    logic [31:0] address;
    logic [31:0] data;
  } cell_state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic        lookup;
    logic        apply;
    logic        any_hit;
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] data;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/store_buffer_with_forwarding_core.sv
// Store buffer with load forwarding: top level with controller and cell row.
//
// Request channel (req_valid/req_stall) carries opcode, address and
// write_data; response channel (rsp_valid/rsp_stall) returns status,
// out_address, out_data and fence_mark, exactly one response per request.
// Entries sit in a row of cells with the oldest in the first cell; a drain
// shifts the whole row one place towards the head, a new write lands in
// the first free cell.
// Each request passes through the transfer, a lookup state in which
// every cell compares its address and registers a hit flag, and an
// apply state which updates the row and loads the response register.
// A new request is taken only when the controller is back in idle, so
// no request is taken before the previous one has left its apply state;
// the compare-then-update sequence across the cell row requires this.
// A stalled response holds in its register; the next request may still be
// taken, and its apply cycle waits until the held response is taken.
// Reset empties the buffer and drops any pending response; no clearing
// pass is needed.
`default_nettype none
`include "store_buffer_with_forwarding_core_macros.svh"

module store_buffer_with_forwarding_core
  import sbf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [2:0]       status,
  output logic [31:0]      out_address,
  output logic [31:0]      out_data,
  output logic             fence_mark
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]  state;
  logic [1:0]  op;
  logic [31:0] addr;
  logic [31:0] wdata;

  cell_cmd_t   cmd;
  cell_state_t cells [DEPTH];
  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] valid_plus;
  logic [31:0] hit_data;
  logic        any_hit;
  logic        apply_go;

  logic [2:0]  status_next;
  logic [31:0] out_address_next;
  logic [31:0] out_data_next;
  logic        fence_mark_next;

  assign req_stall = (state != ST_IDLE);
  assign apply_go  = (state == ST_APPLY) && !(rsp_valid && rsp_stall);

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = cells[i].valid;
      if (hit_vec[i]) begin
        hit_data = hit_data | cells[i].data;
      end
    end
    any_hit    = |hit_vec;
    valid_plus = valid_vec + DEPTH'(1);
  end

  always_comb begin
    cmd.lookup  = (state == ST_LOOK);
    cmd.apply   = apply_go;
    cmd.any_hit = any_hit;
    cmd.opcode  = op;
    cmd.address = addr;
    cmd.data    = wdata;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic        prev_v;
    cell_state_t next_e;
    if (g == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cells[g-1].valid;
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_link
      assign next_e = cells[g+1];
    end
    sbf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_valid (prev_v),
      .next_entry (next_e),
      .entry      (cells[g]),
      .hit        (hit_vec[g])
    );
  end

  always_comb begin
    status_next      = STS_FENCE;
    out_address_next = '0;
    out_data_next    = '0;
    fence_mark_next  = 1'b0;
    unique case (op)
      OP_READ: begin
        status_next      = any_hit ? STS_READ_HIT : STS_READ_MISS;
        out_address_next = addr;
        out_data_next    = hit_data;
      end
      OP_WRITE: begin
        if (any_hit) begin
          status_next = STS_MERGED;
        end else if (cells[DEPTH-1].valid) begin
          status_next = STS_FULL;
        end else begin
          status_next = STS_QUEUED;
        end
      end
      OP_FENCE: begin
        status_next = STS_FENCE;
      end
      OP_DRAIN: begin
        if (cells[0].valid) begin
          status_next      = STS_DRAINED;
          out_address_next = cells[0].address;
          out_data_next    = cells[0].data;
          fence_mark_next  = cells[0].fence;
        end else begin
          status_next = STS_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          // hold until the previous response has been taken
          if (apply_go) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      op    <= opcode;
      addr  <= address;
      wdata <= write_data;
    end
    if (apply_go) begin
      status      <= status_next;
      out_address <= out_address_next;
      out_data    <= out_data_next;
      fence_mark  <= fence_mark_next;
    end
  end

  `SBF_ASSERT(a_transfer_starts_lookup, (req_valid && !req_stall) |=> (state == ST_LOOK))
  `SBF_ASSERT(a_single_hit, $onehot0(hit_vec))
  `SBF_ASSERT(a_entries_packed, (valid_plus & valid_vec) == '0)
  `SBF_ASSERT(a_rsp_from_apply, $rose(rsp_valid) |-> ($past(state) == ST_APPLY))
  `SBF_ASSERT_NORST(a_reset_clears, rst |=> (!rsp_valid && state == ST_IDLE))

endmodule

`default_nettype wire

>>> rtl/sbf_cell.sv
// One entry of the store buffer row: compare, merge, append, mark and shift.
`default_nettype none

module sbf_cell
  import sbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cell_cmd_t   cmd,
  input  wire logic        prev_valid,
  input  wire cell_state_t next_entry,
  output cell_state_t      entry,
  output logic             hit
);

  cell_state_t ent;

  assign entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.fence <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        hit <= ent.valid && (ent.address == cmd.address);
      end
      if (cmd.apply) begin
        unique case (cmd.opcode)
          OP_DRAIN: begin
            // advance towards the head
            ent.valid   <= next_entry.valid;
            ent.fence   <= next_entry.fence;
            ent.address <= next_entry.address;
            ent.data    <= next_entry.data;
          end
          OP_WRITE: begin
            if (hit) begin
              ent.data <= cmd.data;
            end else if (!cmd.any_hit && !ent.valid && prev_valid) begin
              ent.valid   <= 1'b1;
              ent.fence   <= 1'b0;
              ent.address <= cmd.address;
              ent.data    <= cmd.data;
            end
          end
          OP_FENCE: begin
            if (ent.valid && !next_entry.valid) begin
              ent.fence <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
